// File: hdl/laplacian_edge_filter_assert.svh
// Assertion macros shared by the filter RTL.
`ifndef LAPLACIAN_EDGE_FILTER_ASSERT_SVH
`define LAPLACIAN_EDGE_FILTER_ASSERT_SVH

// cond must never hold outside reset
`define LEF_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// ante in one cycle implies cons in the next
`define LEF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/lef_pkg.sv
// Shared types and constants for the Laplacian edge filter.
package lef_pkg;

    localparam int IN_BITS   = 16;
    localparam int EDGE_BITS = 19;
    localparam int CFG_BITS  = 11;

    typedef enum logic [0:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_idx;

    // position flags of one accepted beat
    typedef struct packed {
        logic emit;        // row two or later: a result is due
        logic frame_end;   // last column of the last row
        logic first_col;
        logic last_col;
    } t_pos;

endpackage

// File: hdl/lef_row_mem.sv
// One-read one-write line store, registered read with write-to-read forwarding.
module lef_row_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16,
    parameter int AW    = 10
) (
    input  logic             i_clk,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // a read hitting the entry written in the same cycle gets the new data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/lef_frame_ctl.sv
// Size registers and column/row position counters of the frame.
module lef_frame_ctl #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int CW         = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  lef_pkg::t_cfg_idx         i_cfg_index,
    input  logic [lef_pkg::CFG_BITS-1:0] i_cfg_data,
    input  logic                      i_adv,
    output logic [CW-1:0]             o_col,
    output logic [CW-1:0]             o_right_col,
    output lef_pkg::t_pos             o_pos
);
    import lef_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 2);

    logic [WW-1:0] r_width;
    logic [HW-1:0] r_height;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic          last_row;
    logic [31:0]   cfg_val;

    assign cfg_val = 32'(i_cfg_data);

    // registers are stored already clamped to 1..max
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WW'((MAX_WIDTH < 1024) ? MAX_WIDTH : 1024);
            r_height <= HW'((MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WIDTH: begin
                    if (cfg_val == 32'd0) begin
                        r_width <= WW'(1);
                    end else if (cfg_val > 32'(MAX_WIDTH)) begin
                        r_width <= WW'(MAX_WIDTH);
                    end else begin
                        r_width <= WW'(cfg_val);
                    end
                end
                CFG_HEIGHT: begin
                    if (cfg_val == 32'd0) begin
                        r_height <= HW'(1);
                    end else if (cfg_val > 32'(MAX_HEIGHT)) begin
                        r_height <= HW'(MAX_HEIGHT);
                    end else begin
                        r_height <= HW'(cfg_val);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_pos.last_col  = (32'(r_col) + 32'd1) >= 32'(r_width);
        last_row        = (32'(r_row) + 32'd1) >= (32'(r_height) + 32'd2);
        o_pos.first_col = (r_col == '0);
        o_pos.emit      = 32'(r_row) >= 32'd2;
        o_pos.frame_end = last_row && o_pos.last_col;
        if (o_pos.last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : r_row + RW'(1);
        end else begin
            n_col = r_col + CW'(1);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_adv) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_col       = r_col;
    // on the last column the right neighbor is unused; keep the address in range
    assign o_right_col = o_pos.last_col ? r_col : r_col + CW'(1);

endmodule

// File: hdl/laplacian_edge_filter.sv
// Top level of the streaming 5-point Laplacian edge filter.
//
//  channel | valid      | ready       | payload
//  --------+------------+-------------+-------------------------------
//  input   | i_in_valid | o_in_ready  | i_sample
//  output  | o_out_valid| i_out_ready | o_edge_value, o_frame_end
//  config  | i_cfg_valid| o_cfg_ready | i_cfg_index, i_cfg_data
//
// One sample per cycle unless output stalls; results pass the stage and output registers.
// Rate is set by the line stores: one read and one write per store each cycle.
// Reset clears counters, valids, sizes and the left register; line stores need no clearing pass.
// An output stall holds the output register; with the stage register full, input ready drops.
module laplacian_edge_filter #(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [lef_pkg::IN_BITS-1:0]     i_sample,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic signed [lef_pkg::EDGE_BITS-1:0] o_edge_value,
    output logic                            o_frame_end,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  lef_pkg::t_cfg_idx               i_cfg_index,
    input  logic [lef_pkg::CFG_BITS-1:0]    i_cfg_data
);
    import lef_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int SB = (SAMPLE_BITS < IN_BITS) ? SAMPLE_BITS : IN_BITS;

    logic          in_acc;
    logic          s1_go;
    logic [CW-1:0] col, right_col;
    t_pos          pos;

    logic          r_s1_valid;
    logic [SB-1:0] r_s1_s;
    logic [CW-1:0] r_s1_col;
    t_pos          r_s1_pos;

    logic [SB-1:0] center, up, right_raw;
    logic [SB-1:0] left, right;
    logic [SB-1:0] r_prev_center;

    logic                 r_o_valid;
    logic [EDGE_BITS-1:0] r_edge, n_edge;
    logic                 r_frame_end;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_s1_valid || !r_o_valid || i_out_ready;
    assign in_acc      = i_in_valid && o_in_ready;
    assign s1_go       = r_s1_valid && (!r_o_valid || i_out_ready);

    lef_frame_ctl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CW         (CW)
    ) u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_adv       (in_acc),
        .o_col       (col),
        .o_right_col (right_col),
        .o_pos       (pos)
    );

    // newer row, read at the column: center
    lef_row_mem #(.DEPTH(MAX_WIDTH), .WIDTH(SB), .AW(CW)) u_newer_c (
        .i_clk   (i_clk),
        .i_re    (in_acc),
        .i_raddr (col),
        .o_rdata (center),
        .i_we    (s1_go),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1_s)
    );

    // newer row copy, read one column ahead: right neighbor
    lef_row_mem #(.DEPTH(MAX_WIDTH), .WIDTH(SB), .AW(CW)) u_newer_r (
        .i_clk   (i_clk),
        .i_re    (in_acc),
        .i_raddr (right_col),
        .o_rdata (right_raw),
        .i_we    (s1_go),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1_s)
    );

    // older row: up neighbor; the center moves down into it
    lef_row_mem #(.DEPTH(MAX_WIDTH), .WIDTH(SB), .AW(CW)) u_older (
        .i_clk   (i_clk),
        .i_re    (in_acc),
        .i_raddr (col),
        .o_rdata (up),
        .i_we    (s1_go),
        .i_waddr (r_s1_col),
        .i_wdata (center)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_s   <= i_sample[SB-1:0];
            r_s1_col <= col;
            r_s1_pos <= pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_center <= '0;
        end else if (s1_go) begin
            r_prev_center <= center;
        end
    end

    always_comb begin
        left   = r_s1_pos.first_col ? '0 : r_prev_center;
        right  = r_s1_pos.last_col ? '0 : right_raw;
        // wraps to the result width
        n_edge = EDGE_BITS'(up) + EDGE_BITS'(r_s1_s) + EDGE_BITS'(left)
               + EDGE_BITS'(right) - (EDGE_BITS'(center) << 2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_go) begin
            r_o_valid <= r_s1_pos.emit;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_edge      <= n_edge;
            r_frame_end <= r_s1_pos.frame_end;
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_edge_value = signed'(r_edge);
    assign o_frame_end  = r_frame_end;

`include "laplacian_edge_filter_assert.svh"

    `LEF_ASSERT_NEVER(a_ready_low_only_when_full, i_clk, i_rst_n, !o_in_ready && !(r_s1_valid && r_o_valid && !i_out_ready), "input stalled without a full pipeline")
    `LEF_ASSERT_NEXT(a_emit_reaches_output, i_clk, i_rst_n, s1_go && r_s1_pos.emit, r_o_valid, "due result did not reach the output register")
    `LEF_ASSERT_NEXT(a_stage_refills_on_accept, i_clk, i_rst_n, in_acc, r_s1_valid, "accepted beat lost before the stage register")

endmodule

// File: tb/sv/laplacian_edge_filter_check.sv
`timescale 1ns / 100ps
// Result checker for the Laplacian edge filter: tracks frame position, predicts and compares.
module laplacian_edge_filter_check #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    input  logic                                  i_in_ready,
    input  logic [lef_pkg::IN_BITS-1:0]           i_sample,
    input  logic                                  i_out_valid,
    input  logic                                  i_out_ready,
    input  logic signed [lef_pkg::EDGE_BITS-1:0]  i_edge_value,
    input  logic                                  i_frame_end,
    input  logic                                  i_cfg_valid,
    input  logic                                  i_cfg_ready,
    input  lef_pkg::t_cfg_idx                     i_cfg_index,
    input  logic [lef_pkg::CFG_BITS-1:0]          i_cfg_data,
    output int                                    o_fail_count,
    output int                                    o_pending
);
    import lef_pkg::*;

    typedef struct packed {
        logic signed [EDGE_BITS-1:0] edge_value;
        logic                        frame_end;
    } t_edge_beat;

    logic [CFG_BITS-1:0] width_reg;
    logic [CFG_BITS-1:0] height_reg;
    logic [IN_BITS-1:0]  older_row [MAX_WIDTH];
    logic [IN_BITS-1:0]  newer_row [MAX_WIDTH];
    int unsigned         col_pos;
    int unsigned         row_pos;
    logic [IN_BITS-1:0]  left_carry;
    t_edge_beat          due_edges [$];

    // zero acts as one, anything past the store size as the store size
    function automatic int unsigned clamp_size(input logic [CFG_BITS-1:0] v,
                                               input int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic predict_laplacian(input logic [IN_BITS-1:0] s);
        int unsigned        w;
        int unsigned        h;
        int unsigned        col;
        logic               last_col;
        logic               last_row;
        logic [IN_BITS-1:0] center;
        logic [IN_BITS-1:0] up;
        logic [IN_BITS-1:0] left;
        logic [IN_BITS-1:0] right;
        int                 lap;
        t_edge_beat         due;
        w        = clamp_size(width_reg, MAX_WIDTH);
        h        = clamp_size(height_reg, MAX_HEIGHT);
        col      = col_pos % MAX_WIDTH;
        last_col = (col + 1 >= w);
        last_row = (row_pos + 1 >= h + 2);
        center   = newer_row[col];
        up       = older_row[col];
        left     = (col == 0) ? '0 : left_carry;
        right    = '0;
        if (!last_col) right = newer_row[col + 1];
        // this beat is the lower neighbour of the pixel one row up
        if (row_pos >= 2) begin
            lap = int'(up) + int'(s) + int'(left) + int'(right) - 4 * int'(center);
            due.edge_value = lap[EDGE_BITS-1:0];
            due.frame_end  = last_row && last_col;
            due_edges.push_back(due);
        end
        left_carry     = center;
        older_row[col] = center;
        newer_row[col] = s;
        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end else begin
            col_pos = col + 1;
        end
    endtask

    task automatic compare_edge(input logic signed [EDGE_BITS-1:0] got_value,
                                input logic got_end);
        t_edge_beat want;
        if (due_edges.size() == 0) begin
            $display("%0t: result beat with none expected: edge_value %0d frame_end %0b",
                     $time, got_value, got_end);
            o_fail_count++;
        end else begin
            want = due_edges.pop_front();
            if (got_value !== want.edge_value) begin
                $display("%0t: edge_value expected %0d, got %0d",
                         $time, want.edge_value, got_value);
                o_fail_count++;
            end
            if (got_end !== want.frame_end) begin
                $display("%0t: frame_end expected %0b, got %0b",
                         $time, want.frame_end, got_end);
                o_fail_count++;
            end
        end
    endtask

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = CFG_BITS'(MAX_WIDTH);
            height_reg = CFG_BITS'(MAX_HEIGHT);
            for (int k = 0; k < MAX_WIDTH; k++) begin
                older_row[k] = '0;
                newer_row[k] = '0;
            end
            col_pos    = 0;
            row_pos    = 0;
            left_carry = '0;
            due_edges.delete();
        end else begin
            // results first: a beat accepted on this edge cannot already be out
            if (i_out_valid && i_out_ready) compare_edge(i_edge_value, i_frame_end);
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_WIDTH) width_reg = i_cfg_data;
                else height_reg = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) predict_laplacian(i_sample);
        end
        o_pending = due_edges.size();
    end

endmodule

// File: tb/sv/laplacian_edge_filter_tb.sv
`timescale 1ns / 100ps
// Testbench top for the Laplacian edge filter: clock, reset, stimulus, watchdog and verdict.
module laplacian_edge_filter_tb;
    import lef_pkg::*;

    localparam int MAX_SIZE      = 1024;
    localparam int RANDOM_ITEMS  = 550;
    localparam int STALL_MAX     = 19;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 8;

    logic                        clk        = 1'b0;
    logic                        rst_n      = 1'b0;
    logic                        in_valid   = 1'b0;
    logic                        in_ready;
    logic [IN_BITS-1:0]          in_sample  = '0;
    logic                        out_valid;
    logic                        out_ready  = 1'b0;
    logic signed [EDGE_BITS-1:0] edge_value;
    logic                        frame_end;
    logic                        cfg_valid  = 1'b0;
    logic                        cfg_ready;
    t_cfg_idx                    cfg_index  = CFG_WIDTH;
    logic [CFG_BITS-1:0]         cfg_data   = '0;
    int                          fail_count;
    int                          pending;

    int   in_run     = 0;
    logic in_quiet   = 1'b0;
    int   out_run    = 0;
    logic out_quiet  = 1'b0;
    int   out_gap;
    int   out_hold   = 0;
    logic out_beat   = 1'b0;
    int   idle_cycles = 0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    laplacian_edge_filter DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_sample     (in_sample),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_edge_value (edge_value),
        .o_frame_end  (frame_end),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    laplacian_edge_filter_check edge_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_sample     (in_sample),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_edge_value (edge_value),
        .i_frame_end  (frame_end),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // result side: stall after each beat, with runs of no stalling
    always @(posedge clk) out_beat <= rst_n && out_valid && out_ready;

    always @(negedge clk) begin
        if (out_beat) begin
            if (out_run == 0) begin
                out_run   = $urandom_range(20, 80);
                out_quiet = ($urandom_range(0, 3) == 0);
            end
            out_run--;
            out_gap = out_quiet ? 0 : $urandom_range(0, STALL_MAX);
            out_hold  <= out_gap;
            out_ready <= (out_gap == 0);
        end else if (out_hold > 1) begin
            out_hold <= out_hold - 1;
        end else begin
            out_hold  <= 0;
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_sample(input logic [IN_BITS-1:0] s);
        int gap;
        if (in_run == 0) begin
            in_run   = $urandom_range(20, 80);
            in_quiet = ($urandom_range(0, 3) == 0);
        end
        in_run--;
        gap = in_quiet ? 0 : $urandom_range(0, STALL_MAX);
        @(negedge clk);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        in_sample <= s;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_BITS-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // wait for every expected result, then let the pipeline empty out
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [IN_BITS-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return IN_BITS'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic run_frame(input logic [CFG_BITS-1:0] w_reg,
                             input logic [CFG_BITS-1:0] h_reg, output int count);
        int w_eff;
        int h_eff;
        w_eff = (w_reg == 0) ? 1 : ((w_reg > MAX_SIZE) ? MAX_SIZE : w_reg);
        h_eff = (h_reg == 0) ? 1 : ((h_reg > MAX_SIZE) ? MAX_SIZE : h_reg);
        write_reg(CFG_WIDTH, w_reg);
        write_reg(CFG_HEIGHT, h_reg);
        count = w_eff * (h_eff + 2);
        for (int k = 0; k < count; k++) send_sample(pick_sample());
        settle();
    endtask

    initial begin
        int                  frame_no;
        int                  sent;
        int                  n;
        logic [CFG_BITS-1:0] w_reg;
        logic [CFG_BITS-1:0] h_reg;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // 3x1 frame of extremes: both ends of the result range
        write_reg(CFG_WIDTH, 3);
        write_reg(CFG_HEIGHT, 1);
        send_sample(16'h0000); send_sample(16'hFFFF); send_sample(16'h0000);
        send_sample(16'hFFFF); send_sample(16'h0000); send_sample(16'hFFFF);
        send_sample(16'h0000); send_sample(16'hFFFF); send_sample(16'h0000);
        settle();

        // shrink both registers in the middle of a frame: the next beat ends it
        write_reg(CFG_WIDTH, 4);
        write_reg(CFG_HEIGHT, 3);
        for (int k = 0; k < 11; k++) send_sample(k[0] ? 16'hAAAA : 16'h5555);
        settle();
        write_reg(CFG_WIDTH, 2);
        write_reg(CFG_HEIGHT, 1);
        send_sample(16'h8001);
        settle();

        sent     = 0;
        frame_no = 0;
        while (sent < RANDOM_ITEMS) begin
            if (frame_no == 2) begin
                w_reg = '0;
                h_reg = CFG_BITS'($urandom_range(1, 6));
            end else if (frame_no == 5) begin
                w_reg = CFG_BITS'($urandom_range(1, 8));
                h_reg = '0;
            end else begin
                w_reg = ($urandom_range(0, 7) == 0) ? CFG_BITS'($urandom_range(9, 48))
                                                    : CFG_BITS'($urandom_range(1, 8));
                h_reg = ($urandom_range(0, 9) == 0) ? '0 : CFG_BITS'($urandom_range(1, 6));
            end
            run_frame(w_reg, h_reg, n);
            sent += n;
            frame_no++;
        end

        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/lef_pkg.sv
hdl/lef_row_mem.sv
hdl/lef_frame_ctl.sv
hdl/laplacian_edge_filter.sv
tb/sv/laplacian_edge_filter_check.sv
tb/sv/laplacian_edge_filter_tb.sv
